@@ rtl/core/tat_pkg.sv @@
// Package for the tile animation table: opcodes, entry words and the
// request struct that drives the entry memories. No dependencies.
`timescale 1ns / 1ps

package tat_pkg;

	localparam int TILE_W = 8;
	localparam int WORD_W = 16;

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_LOAD      = 3'd1;
	localparam logic [2:0] OP_SET_SUCC  = 3'd2;
	localparam logic [2:0] OP_SET_DELAY = 3'd3;
	localparam logic [2:0] OP_QUERY     = 3'd4;

	typedef struct packed {
		logic [WORD_W-1:0] link;
		logic [WORD_W-1:0] delay;
	} link_entry_t;

	typedef struct packed {
		logic [WORD_W-1:0] count;
		logic [TILE_W-1:0] shown;
	} anim_entry_t;

	typedef struct packed {
		logic              a_we;
		logic [TILE_W-1:0] a_waddr;
		link_entry_t       a_wdata;
		logic [TILE_W-1:0] a_raddr;
		logic              b_we;
		logic [TILE_W-1:0] b_waddr;
		anim_entry_t       b_wdata;
		logic [TILE_W-1:0] b_raddr;
	} mem_req_t;

endpackage

@@ rtl/core/tile_animation_table.sv @@
// Tile animation table: top level with command sequencer, count register and result word.
// Depends on tat_pkg and tat_store.
`timescale 1ns / 1ps

// After reset the block sweeps both entry memories to zero, one entry a cycle, over
// entries 0 to min(MAX_TILES, 256)-1, and holds cmd_stall high meanwhile. A load, an
// out-of-range index or an unused opcode goes from idle straight to the finish state;
// a set or a query passes through the operand-read state first. A tick walks entries 0
// to min(count, MAX_TILES, 256)-1; an expiring entry also passes through the link and
// delay states, because the successor link and then the new tile's delay come one
// after the other from the single read port of the link/delay memory. The next
// command is taken while the previous result word still waits on rsp_stall.
module tile_animation_table import tat_pkg::*; #(
	parameter int MAX_TILES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         opcode,
	input  logic [7:0]         entry_index,
	input  logic signed [15:0] successor_value,
	input  logic signed [15:0] delay_value,
	input  logic               is_animated,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [7:0]         shown_tile,
	output logic [7:0]         bounded_successor,
	output logic signed [15:0] entry_delay,
	output logic               index_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         cfg_data
);

	localparam int DEPTH = (MAX_TILES > 256) ? 256 : MAX_TILES;
	localparam int SAT_I = (MAX_TILES > 511) ? 511 : MAX_TILES;
	localparam logic [8:0] SAT      = 9'(SAT_I);
	localparam logic [8:0] WLIM     = 9'(DEPTH);
	localparam logic [7:0] CLR_LAST = 8'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_OPRD, S_EV, S_LNK, S_DLY, S_FIN
	} state_t;

	state_t      state_q;
	logic [8:0]  tiles_q;
	logic [7:0]  clr_q;
	logic [8:0]  idx_q;
	logic [2:0]  op_q;
	logic [7:0]  tidx_q;
	logic [15:0] succ_q;
	logic [15:0] dly_q;
	logic [7:0]  shown_q;
	logic [7:0]  nx_q;
	logic [7:0]  p_shown_q;
	logic [7:0]  p_succ_q;
	logic [15:0] p_delay_q;
	logic        p_err_q;
	logic        rsp_valid_q;
	logic [7:0]  rsp_shown_q;
	logic [7:0]  rsp_succ_q;
	logic [15:0] rsp_delay_q;
	logic        rsp_err_q;

	mem_req_t    req;
	link_entry_t a_rdata;
	anim_entry_t b_rdata;

	logic [8:0]  n_cnt;
	logic [8:0]  wn;
	logic [8:0]  idx_nx;
	logic        walk_last;
	logic        bad;
	logic [15:0] cd_dec;
	logic        cd_pos;
	logic        expire;
	logic        link_ok;
	logic [7:0]  nx_tile;
	logic [7:0]  q_succ;

	tat_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.req     (req),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata)
	);

	assign n_cnt     = (tiles_q > SAT) ? SAT : tiles_q;
	assign wn        = (n_cnt > WLIM) ? WLIM : n_cnt;
	assign idx_nx    = idx_q + 9'd1;
	assign walk_last = (idx_nx == wn);
	assign bad       = ({1'b0, entry_index} >= n_cnt);

	assign cd_dec  = b_rdata.count - 16'd1;
	assign cd_pos  = !b_rdata.count[15] && (b_rdata.count != 16'd0);
	assign expire  = cd_pos && (cd_dec == 16'd0);
	assign link_ok = !a_rdata.link[15] && (a_rdata.link < {7'd0, n_cnt});
	assign nx_tile = link_ok ? a_rdata.link[7:0] : shown_q;
	assign q_succ  = link_ok ? a_rdata.link[7:0] : tidx_q;

	always_comb begin
		req = '0;
		case (state_q)
			S_CLR: begin
				req.a_we    = 1'b1;
				req.a_waddr = clr_q;
				req.b_we    = 1'b1;
				req.b_waddr = clr_q;
			end
			S_IDLE: begin
				req.a_raddr = entry_index;
				req.b_raddr = (opcode == OP_TICK) ? 8'd0 : entry_index;
				if (cmd_valid && (opcode == OP_LOAD) && !bad) begin
					req.a_we    = 1'b1;
					req.a_waddr = entry_index;
					req.b_we    = 1'b1;
					req.b_waddr = entry_index;
					req.b_wdata.shown = entry_index;
					if (is_animated) begin
						req.a_wdata.link  = successor_value;
						req.a_wdata.delay = delay_value;
						req.b_wdata.count = delay_value;
					end else begin
						req.a_wdata.link  = {8'd0, entry_index};
						req.a_wdata.delay = 16'd0;
						req.b_wdata.count = 16'd0;
					end
				end
			end
			S_OPRD: begin
				req.a_waddr = tidx_q;
				req.a_wdata = a_rdata;
				if (op_q == OP_SET_SUCC) begin
					req.a_we           = 1'b1;
					req.a_wdata.link   = succ_q;
				end else if (op_q == OP_SET_DELAY) begin
					req.a_we           = 1'b1;
					req.a_wdata.delay  = dly_q;
				end
			end
			S_EV: begin
				if (expire) begin
					req.a_raddr = b_rdata.shown;
				end else begin
					req.b_raddr = idx_nx[7:0];
					if (cd_pos) begin
						req.b_we          = 1'b1;
						req.b_waddr       = idx_q[7:0];
						req.b_wdata.count = cd_dec;
						req.b_wdata.shown = b_rdata.shown;
					end
				end
			end
			S_LNK: begin
				req.a_raddr = nx_tile;
			end
			S_DLY: begin
				req.b_we          = 1'b1;
				req.b_waddr       = idx_q[7:0];
				req.b_wdata.count = a_rdata.delay;
				req.b_wdata.shown = nx_q;
				req.b_raddr       = idx_nx[7:0];
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tiles_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			idx_q       <= '0;
			op_q        <= OP_TICK;
			tidx_q      <= '0;
			succ_q      <= '0;
			dly_q       <= '0;
			shown_q     <= '0;
			nx_q        <= '0;
			p_shown_q   <= '0;
			p_succ_q    <= '0;
			p_delay_q   <= '0;
			p_err_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_shown_q <= '0;
			rsp_succ_q  <= '0;
			rsp_delay_q <= '0;
			rsp_err_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 8'd1;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						op_q      <= opcode;
						tidx_q    <= entry_index;
						succ_q    <= successor_value;
						dly_q     <= delay_value;
						p_shown_q <= '0;
						p_succ_q  <= '0;
						p_delay_q <= '0;
						p_err_q   <= 1'b0;
						case (opcode)
							OP_TICK: begin
								idx_q   <= '0;
								state_q <= (wn == 9'd0) ? S_FIN : S_EV;
							end
							OP_LOAD: begin
								p_err_q <= bad;
								state_q <= S_FIN;
							end
							OP_SET_SUCC, OP_SET_DELAY, OP_QUERY: begin
								p_err_q <= bad;
								state_q <= bad ? S_FIN : S_OPRD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_OPRD: begin
					if (op_q == OP_QUERY) begin
						p_shown_q <= b_rdata.shown;
						p_succ_q  <= q_succ;
						p_delay_q <= a_rdata.delay;
					end
					state_q <= S_FIN;
				end
				S_EV: begin
					if (expire) begin
						shown_q <= b_rdata.shown;
						state_q <= S_LNK;
					end else if (walk_last) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_nx;
					end
				end
				S_LNK: begin
					nx_q    <= nx_tile;
					state_q <= S_DLY;
				end
				S_DLY: begin
					if (walk_last) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_EV;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_shown_q <= p_shown_q;
						rsp_succ_q  <= p_succ_q;
						rsp_delay_q <= p_delay_q;
						rsp_err_q   <= p_err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall         = (state_q != S_IDLE);
	assign cfg_ready         = 1'b1;
	assign rsp_valid         = rsp_valid_q;
	assign shown_tile        = rsp_shown_q;
	assign bounded_successor = rsp_succ_q;
	assign entry_delay       = rsp_delay_q;
	assign index_error       = rsp_err_q;

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV || state_q == S_LNK || state_q == S_DLY) |-> (idx_q < wn))
		else $error("tick walk index beyond active entries");

	a_walk_no_link_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV || state_q == S_LNK || state_q == S_DLY) |-> !req.a_we)
		else $error("tick wrote the link/delay memory");

	a_oprd_no_anim_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OPRD) |-> !req.b_we)
		else $error("set or query wrote the countdown memory");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && rsp_valid_q && rsp_stall) |=> (state_q == S_FIN))
		else $error("result word overwritten while stalled");

endmodule

@@ rtl/core/tat_store.sv @@
// Entry storage of the tile animation table: link/delay memory and
// countdown/shown memory, one write and one registered read port each.
// Depends on tat_pkg.
`timescale 1ns / 1ps

module tat_store import tat_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  mem_req_t    req,
	output link_entry_t a_rdata,
	output anim_entry_t b_rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	link_entry_t mem_a [DEPTH];
	anim_entry_t mem_b [DEPTH];
	link_entry_t a_rdata_q;
	anim_entry_t b_rdata_q;

	always_ff @(posedge clk) begin
		if (req.a_we) begin
			mem_a[req.a_waddr[AW-1:0]] <= req.a_wdata;
		end
		a_rdata_q <= mem_a[req.a_raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (req.b_we) begin
			mem_b[req.b_waddr[AW-1:0]] <= req.b_wdata;
		end
		b_rdata_q <= mem_b[req.b_raddr[AW-1:0]];
	end

	assign a_rdata = a_rdata_q;
	assign b_rdata = b_rdata_q;

endmodule
